// ===== sv/dvdn_pkg.sv =====
package dvdn_pkg;

   // Field widths
   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int LEN_W    = 5;
   localparam int RD_W     = 23;
   localparam int STATUS_W = 2;

   // Internal widths: shifted year, quotient by 100, month offset, running sum
   localparam int T_W      = YEAR_W + 1;
   localparam int Q_W      = 8;
   localparam int OFF_W    = 9;
   localparam int SUM_W    = 24;
   localparam int RECIP_W  = 13;
   localparam int PROD_W   = T_W + RECIP_W;

   // Register port
   localparam int ADDR_W   = 3;
   localparam int DATA_W   = 32;

   localparam logic [YEAR_W-1:0] LOW_YEAR_RST = 14'd1500;
   localparam logic [YEAR_W-1:0] CUR_YEAR_RST = 14'd2021;

   // Calendar constants
   localparam logic [T_W-1:0]     YEAR_SHIFT    = 15'd400;
   localparam logic [T_W-1:0]     CENTURY       = 15'd100;
   localparam logic [8:0]         DAYS_PER_YEAR = 9'd365;
   localparam logic [SUM_W-1:0]   RD_BIAS       = 24'd146403;
   localparam logic [MONTH_W-1:0] MONTH_JAN     = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB     = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_MAR     = 4'd3;
   localparam logic [MONTH_W-1:0] MONTH_DEC     = 4'd12;
   localparam logic [LEN_W-1:0]   MIN_MONTH_LEN = 5'd28;

   // floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT, exact for x below 2^15
   localparam logic [RECIP_W-1:0] RECIP_100   = 13'd5243;
   localparam int                 RECIP_SHIFT = 19;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_YEAR  = 2'd1,
      ST_MONTH = 2'd2,
      ST_DAY   = 2'd3
   } status_type;

   typedef enum logic {
      REG_LOW_YEAR = 1'b0,
      REG_CUR_YEAR = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [YEAR_W-1:0] low_year;
      logic [YEAR_W-1:0] current_year;
   } cfg_type;

   // Days before the first of the month, counted from the first of March
   function automatic logic [OFF_W-1:0] month_offset(input logic [MONTH_W-1:0] m);
      logic [OFF_W-1:0] off;
      case (m)
         4'd3:    off = 9'd0;
         4'd4:    off = 9'd31;
         4'd5:    off = 9'd61;
         4'd6:    off = 9'd92;
         4'd7:    off = 9'd122;
         4'd8:    off = 9'd153;
         4'd9:    off = 9'd184;
         4'd10:   off = 9'd214;
         4'd11:   off = 9'd245;
         4'd12:   off = 9'd275;
         4'd1:    off = 9'd306;
         4'd2:    off = 9'd337;
         default: off = 9'd0;
      endcase
      return off;
   endfunction

   // Length of a month in a common year, zero for a code that is no month
   function automatic logic [LEN_W-1:0] base_length(input logic [MONTH_W-1:0] m);
      logic [LEN_W-1:0] len;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
         4'd2:                                        len = 5'd28;
         default:                                     len = 5'd0;
      endcase
      return len;
   endfunction

endpackage

// ===== sv/dvdn_if.sv =====
interface dvdn_req_if import dvdn_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [YEAR_W-1:0]  year;
   logic [MONTH_W-1:0] month;
   logic [DAY_W-1:0]   day;

   modport source (output valid, year, month, day, input ready);
   modport sink   (input valid, year, month, day, output ready);
endinterface

interface dvdn_rsp_if import dvdn_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [LEN_W-1:0]    month_length;
   logic [RD_W-1:0]     day_number;

   modport source (output valid, status, month_length, day_number, input ready);
   modport sink   (input valid, status, month_length, day_number, output ready);
endinterface

// ===== sv/dvdn_csr.sv =====
module dvdn_csr import dvdn_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   logic              wr_en;
   reg_index_type     index;
   logic [YEAR_W-1:0] low_year_ff, low_year_in;
   logic [YEAR_W-1:0] cur_year_ff, cur_year_in;
   logic [YEAR_W-1:0] rd_value;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign index  = reg_index_type'(paddr[2]);

   // Decode the write transfer
   always_comb begin
      low_year_in = low_year_ff;
      cur_year_in = cur_year_ff;
      if (wr_en) begin
         unique case (index)
            REG_LOW_YEAR: low_year_in = pwdata[YEAR_W-1:0];
            REG_CUR_YEAR: cur_year_in = pwdata[YEAR_W-1:0];
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_year_ff <= LOW_YEAR_RST;
         cur_year_ff <= CUR_YEAR_RST;
      end else begin
         low_year_ff <= low_year_in;
         cur_year_ff <= cur_year_in;
      end
   end

   // Read back
   always_comb begin
      unique case (index)
         REG_LOW_YEAR: rd_value = low_year_ff;
         REG_CUR_YEAR: rd_value = cur_year_ff;
         default:      rd_value = '0;
      endcase
   end

   assign prdata           = DATA_W'(rd_value);
   assign cfg.low_year     = low_year_ff;
   assign cfg.current_year = cur_year_ff;

endmodule

// ===== sv/date_validate_day_number.sv =====
// Gregorian date checker: each date (year, month, day) is checked against the year window
// [lowest year, current_year+1], then month 1..12, then day 1..month length with the Gregorian
// leap rule, and returns a status, the month length and the Rata Die day number
// (0001-01-01 is day 1, zero unless the status is OK). One date is taken every clock cycle
// while the result side does not hold the pipeline back; each result passes through the four
// register stages of the datapath (capture and range checks, constant multiplications for
// the quotients by 100 and the year's days, leap rule and summation, bias removal into the
// output register) before it is offered. Backpressure on the result side holds a stage only
// while the stage after it is full, so empty stages still fill and no date is lost or repeated.
// Registers: lowest year at byte address 0, current_year at 4.
module date_validate_day_number import dvdn_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   dvdn_req_if.sink          req_ch,
   dvdn_rsp_if.source        rsp_ch,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   cfg_type cfg;

   dvdn_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Stage enables: a stage loads when empty or when its content moves on
   logic adv1, adv2, adv3, adv4;
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;

   assign adv4 = !s4_valid_ff || rsp_ch.ready;
   assign adv3 = !s3_valid_ff || adv4;
   assign adv2 = !s2_valid_ff || adv3;
   assign adv1 = !s1_valid_ff || adv2;
   assign req_ch.ready = adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (adv1) s1_valid_ff <= req_ch.valid;
         if (adv2) s2_valid_ff <= s1_valid_ff;
         if (adv3) s3_valid_ff <= s2_valid_ff;
         if (adv4) s4_valid_ff <= s3_valid_ff;
      end
   end

   // ---------------- Stage 1: capture, range checks, shifted year, month offset
   logic               year_ok_in, month_ok_in, early_in;
   logic [T_W-1:0]     t_in;
   logic [T_W-1:0]     max_year;
   logic [YEAR_W-1:0]  s1_year_ff;
   logic [MONTH_W-1:0] s1_month_ff;
   logic [DAY_W-1:0]   s1_day_ff;
   logic               s1_year_ok_ff, s1_month_ok_ff;
   logic [T_W-1:0]     s1_t_ff;
   logic [OFF_W-1:0]   s1_off_ff;

   always_comb begin
      max_year    = T_W'(cfg.current_year) + T_W'(1);
      year_ok_in  = (req_ch.year >= cfg.low_year) && (T_W'(req_ch.year) <= max_year);
      month_ok_in = (req_ch.month >= MONTH_JAN) && (req_ch.month <= MONTH_DEC);
      early_in    = req_ch.month < MONTH_MAR;
      // January and February count as months of the previous year
      t_in        = T_W'(req_ch.year) + YEAR_SHIFT - T_W'(early_in);
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_year_ff     <= req_ch.year;
         s1_month_ff    <= req_ch.month;
         s1_day_ff      <= req_ch.day;
         s1_year_ok_ff  <= year_ok_in;
         s1_month_ok_ff <= month_ok_in;
         s1_t_ff        <= t_in;
         s1_off_ff      <= month_offset(req_ch.month);
      end
   end

   // ---------------- Stage 2: constant multiplications
   logic [SUM_W-1:0]   t365_in;
   logic [PROD_W-1:0]  t_prod, y_prod;
   logic [YEAR_W-1:0]  s2_year_ff;
   logic [MONTH_W-1:0] s2_month_ff;
   logic [DAY_W-1:0]   s2_day_ff;
   logic               s2_year_ok_ff, s2_month_ok_ff;
   logic [T_W-1:0]     s2_t_ff;
   logic [OFF_W-1:0]   s2_off_ff;
   logic [SUM_W-1:0]   s2_t365_ff;
   logic [Q_W-1:0]     s2_tq_ff, s2_yq_ff;

   always_comb begin
      t365_in = SUM_W'(s1_t_ff) * SUM_W'(DAYS_PER_YEAR);
      t_prod  = PROD_W'(s1_t_ff) * PROD_W'(RECIP_100);
      y_prod  = PROD_W'(s1_year_ff) * PROD_W'(RECIP_100);
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         s2_year_ff     <= s1_year_ff;
         s2_month_ff    <= s1_month_ff;
         s2_day_ff      <= s1_day_ff;
         s2_year_ok_ff  <= s1_year_ok_ff;
         s2_month_ok_ff <= s1_month_ok_ff;
         s2_t_ff        <= s1_t_ff;
         s2_off_ff      <= s1_off_ff;
         s2_t365_ff     <= t365_in;
         s2_tq_ff       <= t_prod[RECIP_SHIFT +: Q_W];
         s2_yq_ff       <= y_prod[RECIP_SHIFT +: Q_W];
      end
   end

   // ---------------- Stage 3: leap rule, month length, status, day sum
   logic [T_W-1:0]   yq_x100;
   logic             cent_in, leap_in;
   logic [LEN_W-1:0] len_in;
   status_type       status_in;
   logic [SUM_W-1:0] sum_in;
   status_type       s3_status_ff;
   logic [LEN_W-1:0] s3_len_ff;
   logic [SUM_W-1:0] s3_sum_ff;

   always_comb begin
      yq_x100 = T_W'(s2_yq_ff) * CENTURY;
      cent_in = yq_x100 == T_W'(s2_year_ff);
      // divisible by 4 and not by 100, or by 400
      leap_in = (s2_year_ff[1:0] == 2'b00) && (!cent_in || (s2_yq_ff[1:0] == 2'b00));
      len_in  = base_length(s2_month_ff)
              + LEN_W'((s2_month_ff == MONTH_FEB) && leap_in);

      // first failing check decides
      if (!s2_year_ok_ff) begin
         status_in = ST_YEAR;
      end else if (!s2_month_ok_ff) begin
         status_in = ST_MONTH;
      end else if ((s2_day_ff == '0) || (LEN_W'(s2_day_ff) > len_in)) begin
         status_in = ST_DAY;
      end else begin
         status_in = ST_OK;
      end

      sum_in = s2_t365_ff
             + SUM_W'(s2_t_ff >> 2)
             - SUM_W'(s2_tq_ff)
             + SUM_W'(s2_tq_ff >> 2)
             + SUM_W'(s2_off_ff)
             + SUM_W'(s2_day_ff);
   end

   always_ff @(posedge clock) begin
      if (adv3) begin
         s3_status_ff <= status_in;
         s3_len_ff    <= len_in;
         s3_sum_ff    <= sum_in;
      end
   end

   // ---------------- Stage 4: remove bias, clamp, output register
   logic [RD_W-1:0]  rd_in;
   logic [SUM_W-1:0] unbiased;
   status_type       s4_status_ff;
   logic [LEN_W-1:0] s4_len_ff;
   logic [RD_W-1:0]  s4_rd_ff;

   always_comb begin
      unbiased = s3_sum_ff - RD_BIAS;
      if ((s3_status_ff == ST_OK) && (s3_sum_ff > RD_BIAS)) begin
         rd_in = unbiased[RD_W-1:0];
      end else begin
         rd_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv4) begin
         s4_status_ff <= s3_status_ff;
         s4_len_ff    <= s3_len_ff;
         s4_rd_ff     <= rd_in;
      end
   end

   assign rsp_ch.valid        = s4_valid_ff;
   assign rsp_ch.status       = s4_status_ff;
   assign rsp_ch.month_length = s4_len_ff;
   assign rsp_ch.day_number   = s4_rd_ff;

   // ---------------- Checks
   a_rd_zero_on_fail: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.status != ST_OK)) |-> (rsp_ch.day_number == '0))
      else $error("day number nonzero on a failed date");

   a_len_zero_bad_month: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.status == ST_MONTH)) |-> (rsp_ch.month_length == '0))
      else $error("month length nonzero for a bad month");

   a_len_ok_month: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.status == ST_OK)) |-> (rsp_ch.month_length >= MIN_MONTH_LEN))
      else $error("accepted date with a short month length");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_ch.valid)
      else $error("result offered straight after reset");

endmodule
